>>> src/ntc_pkg.sv
// ----------------------------------------------------------------------------
// ntc_pkg
// Format codes, stage record and helpers shared by the converter modules.
// ----------------------------------------------------------------------------
package ntc_pkg;

    localparam logic [2:0] FMT_U32 = 3'd0;
    localparam logic [2:0] FMT_U64 = 3'd1;
    localparam logic [2:0] FMT_S32 = 3'd2;
    localparam logic [2:0] FMT_S64 = 3'd3;
    localparam logic [2:0] FMT_F32 = 3'd4;
    localparam logic [2:0] FMT_F64 = 3'd5;

    localparam int EXP_W = 14;

    typedef logic signed [EXP_W-1:0] exp_t;

    typedef struct packed {
        logic        direct;
        logic [63:0] res;
        logic        flag;
        logic        neg;
        logic        zero;
        logic        tgt64;
        logic [63:0] norm;
        exp_t        top;
    } s1_t;

    function automatic logic [6:0] lzc64(input logic [63:0] x);
        logic [6:0] n;
        n = 7'd64;
        for (int i = 0; i < 64; i++)
        begin
            if (x[i])
            begin
                n = 7'(63 - i);
            end
        end
        return n;
    endfunction

endpackage

>>> src/ntc_if.sv
// ----------------------------------------------------------------------------
// ntc_if
// Valid/ready channels carrying conversion requests and results.
// ----------------------------------------------------------------------------
interface ntc_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  source_format;
    logic [2:0]  target_format;
    logic [63:0] value_bits;

    modport source (output valid, source_format, target_format, value_bits, input ready);
    modport sink (input valid, source_format, target_format, value_bits, output ready);
endinterface

interface ntc_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_bits;
    logic        out_of_range;

    modport source (output valid, result_bits, out_of_range, input ready);
    modport sink (input valid, result_bits, out_of_range, output ready);
endinterface

>>> src/ntc_unpack.sv
// ----------------------------------------------------------------------------
// ntc_unpack
// Decode the source word, finish integer and special cases, normalize the rest.
// ----------------------------------------------------------------------------
module ntc_unpack
    import ntc_pkg::*;
(
    input  logic [2:0]  source_format,
    input  logic [2:0]  target_format,
    input  logic [63:0] value_bits,
    output s1_t         s1
);

    logic         sgn_src;
    logic         neg;
    logic         nan;
    logic         inf;
    logic [63:0]  w;
    logic [63:0]  mag;
    logic [63:0]  m;
    exp_t         e;
    logic [10:0]  x;
    logic [51:0]  frac;
    logic [6:0]   lz;
    logic [127:0] prod;
    logic         big;
    logic [63:0]  imag;
    logic [63:0]  pos_max;
    logic [63:0]  neg_lim;
    logic [63:0]  r;
    logic         narrow;
    logic         uns;
    exp_t         ne;

    always_comb
    begin
        s1       = '0;
        sgn_src  = (source_format == FMT_S32) || (source_format == FMT_S64);
        w        = value_bits;
        neg      = 1'b0;
        nan      = 1'b0;
        inf      = 1'b0;
        mag      = '0;
        m        = '0;
        e        = '0;
        x        = '0;
        frac     = '0;
        lz       = '0;
        prod     = '0;
        big      = 1'b0;
        imag     = '0;
        r        = '0;
        ne       = '0;
        narrow   = (target_format == FMT_U32) || (target_format == FMT_S32);
        uns      = (target_format == FMT_U32) || (target_format == FMT_U64);
        s1.tgt64 = (target_format == FMT_F64);
        unique case (target_format)
            FMT_U32:
            begin
                pos_max = 64'h0000_0000_FFFF_FFFF;
                neg_lim = '0;
            end
            FMT_U64:
            begin
                pos_max = '1;
                neg_lim = '0;
            end
            FMT_S32:
            begin
                pos_max = 64'h0000_0000_7FFF_FFFF;
                neg_lim = 64'h0000_0000_8000_0000;
            end
            default:
            begin
                pos_max = 64'h7FFF_FFFF_FFFF_FFFF;
                neg_lim = 64'h8000_0000_0000_0000;
            end
        endcase
        if (source_format == target_format)
        begin
            s1.direct = 1'b1;
            s1.res    = value_bits;
        end
        else if (source_format > FMT_F64 || target_format > FMT_F64)
        begin
            s1.direct = 1'b1;
        end
        else if (source_format < FMT_F32)
        begin
            if (source_format == FMT_U32)
            begin
                w = {32'b0, value_bits[31:0]};
            end
            else if (source_format == FMT_S32)
            begin
                w = {{32{value_bits[31]}}, value_bits[31:0]};
            end
            neg = sgn_src && w[63];
            mag = neg ? (64'd0 - w) : w;
            if (target_format < FMT_F32)
            begin
                s1.direct = 1'b1;
                s1.res    = narrow ? {32'b0, w[31:0]} : w;
            end
            else
            begin
                lz      = lzc64(mag);
                s1.neg  = neg;
                s1.zero = (mag == '0);
                s1.norm = mag << lz[5:0];
                s1.top  = exp_t'(63) - exp_t'(lz);
            end
        end
        else
        begin
            if (source_format == FMT_F32)
            begin
                neg  = value_bits[31];
                x    = {3'b0, value_bits[30:23]};
                frac = {29'b0, value_bits[22:0]};
                nan  = (x == 11'hFF) && (frac != '0);
                inf  = (x == 11'hFF) && (frac == '0);
                if (x == '0)
                begin
                    m = {41'b0, value_bits[22:0]};
                    e = -exp_t'(149);
                end
                else
                begin
                    m = {40'b0, 1'b1, value_bits[22:0]};
                    e = exp_t'(x) - exp_t'(150);
                end
            end
            else
            begin
                neg  = value_bits[63];
                x    = value_bits[62:52];
                frac = value_bits[51:0];
                nan  = (x == 11'h7FF) && (frac != '0);
                inf  = (x == 11'h7FF) && (frac == '0);
                if (x == '0)
                begin
                    m = {12'b0, frac};
                    e = -exp_t'(1074);
                end
                else
                begin
                    m = {11'b0, 1'b1, frac};
                    e = exp_t'(x) - exp_t'(1075);
                end
            end
            if (target_format < FMT_F32)
            begin
                s1.direct = 1'b1;
                big       = inf;
                if (!nan && !inf && m != '0)
                begin
                    if (e >= exp_t'(64))
                    begin
                        big = 1'b1;
                    end
                    else if (e >= exp_t'(0))
                    begin
                        prod = {64'b0, m} << e[5:0];
                        big  = (prod[127:64] != '0);
                        imag = prod[63:0];
                    end
                    else if (e > -exp_t'(64))
                    begin
                        ne   = -e;
                        imag = m >> ne[5:0];
                    end
                end
                if (nan)
                begin
                    s1.flag = 1'b1;
                    r       = pos_max;
                end
                else if (!neg)
                begin
                    s1.flag = big || (imag > pos_max);
                    r       = s1.flag ? pos_max : imag;
                end
                else
                begin
                    s1.flag = big || (imag > neg_lim);
                    r       = s1.flag ? (uns ? 64'd0 : (64'd0 - neg_lim)) : (64'd0 - imag);
                end
                s1.res = narrow ? {32'b0, r[31:0]} : r;
            end
            else if (nan || inf)
            begin
                s1.direct = 1'b1;
                if (target_format == FMT_F64)
                begin
                    s1.res = {neg, 63'h7FF0_0000_0000_0000};
                    if (nan)
                    begin
                        s1.res = {neg, 63'h7FF8_0000_0000_0000} | {11'b0, frac[22:0], 29'b0};
                    end
                end
                else
                begin
                    s1.res = {32'b0, neg, 31'h7F80_0000};
                    if (nan)
                    begin
                        s1.res = {32'b0, neg, 31'h7FC0_0000} | {41'b0, frac[51:29]};
                    end
                end
            end
            else
            begin
                lz      = lzc64(m);
                s1.neg  = neg;
                s1.zero = (m == '0);
                s1.norm = m << lz[5:0];
                s1.top  = e + exp_t'(63) - exp_t'(lz);
            end
        end
    end

endmodule

>>> src/ntc_pack.sv
// ----------------------------------------------------------------------------
// ntc_pack
// Round a normalized magnitude to nearest even and pack it as f32 or f64.
// ----------------------------------------------------------------------------
module ntc_pack
    import ntc_pkg::*;
(
    input  s1_t         s1,
    output logic [63:0] result_bits,
    output logic        out_of_range
);

    exp_t        mb;
    exp_t        bias;
    exp_t        lsb;
    exp_t        minlsb;
    exp_t        k;
    exp_t        sh;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] kx;
    logic [63:0] bits;
    logic [63:0] emax;

    always_comb
    begin
        mb     = s1.tgt64 ? exp_t'(52) : exp_t'(23);
        bias   = s1.tgt64 ? exp_t'(1023) : exp_t'(127);
        emax   = s1.tgt64 ? 64'h7FF0_0000_0000_0000 : 64'h0000_0000_7F80_0000;
        lsb    = s1.top - mb;
        minlsb = exp_t'(1) - bias - mb;
        k      = s1.top + bias - exp_t'(1);
        if (lsb < minlsb)
        begin
            lsb = minlsb;
            k   = '0;
        end
        sh   = lsb - s1.top + exp_t'(63);
        rem  = '0;
        half = '0;
        if (sh >= exp_t'(64))
        begin
            q = (sh == exp_t'(64) && s1.norm > 64'h8000_0000_0000_0000) ? 64'd1 : 64'd0;
        end
        else
        begin
            q    = s1.norm >> sh[5:0];
            rem  = s1.norm & ((64'd1 << sh[5:0]) - 64'd1);
            half = 64'd1 << (sh[5:0] - 6'd1);
            if (rem > half || (rem == half && q[0]))
            begin
                q = q + 64'd1;
            end
        end
        kx   = {{(64-EXP_W){1'b0}}, k};
        bits = (s1.tgt64 ? (kx << 52) : (kx << 23)) + q;
        if (bits >= emax)
        begin
            bits = emax;
        end
        if (s1.zero)
        begin
            bits = '0;
        end
        if (s1.direct)
        begin
            result_bits = s1.res;
        end
        else if (s1.tgt64)
        begin
            result_bits = {s1.neg, bits[62:0]};
        end
        else
        begin
            result_bits = {32'b0, s1.neg, bits[30:0]};
        end
        out_of_range = s1.direct && s1.flag;
    end

endmodule

>>> src/numeric_type_converter.sv
// ----------------------------------------------------------------------------
// numeric_type_converter
// Converts a 64-bit word between u32, u64, s32, s64, f32 and f64 formats.
// ----------------------------------------------------------------------------
// Three-stage pipeline: input register, a register after decode and
// normalization (leading-zero count and shift), and the result register
// after rounding and packing. One conversion is accepted every cycle while
// in.ready is high; all stages advance together whenever the result register
// is empty or being taken, so in.ready drops whenever a result waits and is
// not taken, even with bubbles behind it.
module numeric_type_converter
    import ntc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ntc_in_if.sink    in_ch,
    ntc_out_if.source out_ch
);

    logic        v0_reg;
    logic        v1_reg;
    logic        v2_reg;
    logic [2:0]  sf_reg;
    logic [2:0]  tf_reg;
    logic [63:0] val_reg;
    s1_t         s1_next;
    s1_t         s1_reg;
    logic [63:0] res_next;
    logic        flag_next;
    logic [63:0] res_reg;
    logic        flag_reg;
    logic        advance;

    assign advance     = !v2_reg || out_ch.ready;
    assign in_ch.ready = advance;

    ntc_unpack u_unpack (
        .source_format (sf_reg),
        .target_format (tf_reg),
        .value_bits    (val_reg),
        .s1            (s1_next)
    );

    ntc_pack u_pack (
        .s1           (s1_reg),
        .result_bits  (res_next),
        .out_of_range (flag_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (advance)
        begin
            v0_reg <= in_ch.valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sf_reg   <= in_ch.source_format;
            tf_reg   <= in_ch.target_format;
            val_reg  <= in_ch.value_bits;
            s1_reg   <= s1_next;
            res_reg  <= res_next;
            flag_reg <= flag_next;
        end
    end

    assign out_ch.valid        = v2_reg;
    assign out_ch.result_bits  = res_reg;
    assign out_ch.out_of_range = flag_reg;

endmodule

>>> src/ntc_checker.sv
// ----------------------------------------------------------------------------
// ntc_checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
module ntc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] result_bits,
    input logic        out_of_range
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_bits))
        else $error("result changed while stalled");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a waiting result");

    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |->
            result_bits == 64'h0 || result_bits == 64'hFFFF_FFFF ||
            result_bits == 64'hFFFF_FFFF_FFFF_FFFF || result_bits == 64'h7FFF_FFFF ||
            result_bits == 64'h7FFF_FFFF_FFFF_FFFF || result_bits == 64'h8000_0000 ||
            result_bits == 64'h8000_0000_0000_0000)
        else $error("flagged result is not a saturation value");

endmodule

bind numeric_type_converter ntc_checker u_ntc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .result_bits  (out_ch.result_bits),
    .out_of_range (out_ch.out_of_range)
);

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives conversion requests through numeric_type_converter with random
// idling on both channels and checks every result against a bit-exact
// predictor of the integer and float conversions.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ntc_pkg::*;

    typedef struct packed {
        logic [2:0]  sf;
        logic [2:0]  tf;
        logic [63:0] v;
    } conv_req_t;

    typedef struct packed {
        logic [63:0] bits;
        logic        oor;
    } conv_res_t;

    typedef struct {
        logic           neg;
        int             cls;
        logic [63:0]    m;
        int             e;
        logic [63:0]    frac;
    } fp_split_t;

    localparam int WATCHDOG_LIMIT = 2000;

    logic clk;
    logic rst_n;

    ntc_in_if  in_ch ();
    ntc_out_if out_ch ();

    numeric_type_converter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    conv_req_t pending_reqs[$];
    conv_res_t expected_results[$];
    int        send_idle_pct;
    int        recv_stall_pct;
    int        error_count;
    int        quiet_cycles;
    bit        stimulus_done;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] pack_fp(input logic neg, input logic [63:0] m_in,
                                            input int e_in, input int eb, input int mb);
        logic [63:0] m;
        logic [63:0] sgn;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] bits;
        logic [63:0] emax;
        int e;
        int bias;
        int top;
        int lsb;
        int minlsb;
        int k;
        int sh;
        m = m_in;
        e = e_in;
        sgn = neg ? (64'd1 << (eb + mb)) : 64'd0;
        if (m == 64'd0)
        begin
            return sgn;
        end
        while (m[63] == 1'b0)
        begin
            m = m << 1;
            e--;
        end
        bias = (1 << (eb - 1)) - 1;
        top = e + 63;
        lsb = top - mb;
        minlsb = 1 - bias - mb;
        k = top + bias - 1;
        if (lsb < minlsb)
        begin
            lsb = minlsb;
            k = 0;
        end
        sh = lsb - e;
        if (sh >= 64)
        begin
            q = (sh == 64 && m > 64'h8000000000000000) ? 64'd1 : 64'd0;
        end
        else
        begin
            rem = m & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            q = m >> sh;
            if (rem > half || (rem == half && q[0]))
            begin
                q++;
            end
        end
        bits = (64'(k) << mb) + q;
        emax = ((64'd1 << eb) - 64'd1) << mb;
        if (bits >= emax)
        begin
            bits = emax;
        end
        return sgn | bits;
    endfunction

    function automatic fp_split_t split_fp(input logic [63:0] v, input int eb, input int mb);
        fp_split_t p;
        int bias;
        logic [63:0] xmax;
        logic [63:0] x;
        bias = (1 << (eb - 1)) - 1;
        xmax = (64'd1 << eb) - 64'd1;
        x = (v >> mb) & xmax;
        p.frac = v & ((64'd1 << mb) - 64'd1);
        p.neg = v[eb + mb];
        p.cls = 0;
        p.m = 64'd0;
        p.e = 0;
        if (x == xmax)
        begin
            p.cls = (p.frac != 64'd0) ? 2 : 1;
        end
        else if (x == 64'd0)
        begin
            p.m = p.frac;
            p.e = 1 - bias - mb;
        end
        else
        begin
            p.m = p.frac | (64'd1 << mb);
            p.e = int'(x) - bias - mb;
        end
        return p;
    endfunction

    function automatic conv_res_t fp_to_int(input fp_split_t p, input logic [2:0] tf);
        conv_res_t r;
        logic [63:0] pos_max;
        logic [63:0] neg_lim;
        logic [63:0] mag;
        logic [63:0] val;
        logic big;
        logic unsigned_tgt;
        logic narrow;
        unsigned_tgt = (tf == FMT_U32 || tf == FMT_U64);
        narrow = (tf == FMT_U32 || tf == FMT_S32);
        mag = 64'd0;
        big = 1'b0;
        r.oor = 1'b0;
        case (tf)
            FMT_U32:
            begin
                pos_max = 64'hFFFFFFFF;
                neg_lim = 64'd0;
            end
            FMT_U64:
            begin
                pos_max = '1;
                neg_lim = 64'd0;
            end
            FMT_S32:
            begin
                pos_max = 64'h7FFFFFFF;
                neg_lim = 64'h80000000;
            end
            default:
            begin
                pos_max = 64'h7FFFFFFFFFFFFFFF;
                neg_lim = 64'h8000000000000000;
            end
        endcase
        if (p.cls == 2)
        begin
            r.oor = 1'b1;
            r.bits = pos_max;
            return r;
        end
        if (p.cls == 1)
        begin
            big = 1'b1;
        end
        else if (p.m != 64'd0)
        begin
            if (p.e >= 64)
            begin
                big = 1'b1;
            end
            else if (p.e >= 0)
            begin
                if (p.m > ({64{1'b1}} >> p.e))
                begin
                    big = 1'b1;
                end
                else
                begin
                    mag = p.m << p.e;
                end
            end
            else if (p.e > -64)
            begin
                mag = p.m >> (-p.e);
            end
        end
        if (!p.neg)
        begin
            if (big || mag > pos_max)
            begin
                r.oor = 1'b1;
                val = pos_max;
            end
            else
            begin
                val = mag;
            end
        end
        else
        begin
            if (big || mag > neg_lim)
            begin
                r.oor = 1'b1;
                val = unsigned_tgt ? 64'd0 : (64'd0 - neg_lim);
            end
            else
            begin
                val = 64'd0 - mag;
            end
        end
        r.bits = narrow ? (val & 64'hFFFFFFFF) : val;
        return r;
    endfunction

    function automatic conv_res_t predict_conversion(input conv_req_t q);
        conv_res_t r;
        fp_split_t p;
        logic [63:0] w;
        logic neg;
        r.bits = 64'd0;
        r.oor = 1'b0;
        if (q.sf == q.tf)
        begin
            r.bits = q.v;
            return r;
        end
        if (q.sf > FMT_F64 || q.tf > FMT_F64)
        begin
            return r;
        end
        if (q.sf < FMT_F32)
        begin
            case (q.sf)
                FMT_U32: w = {32'd0, q.v[31:0]};
                FMT_S32: w = {{32{q.v[31]}}, q.v[31:0]};
                default: w = q.v;
            endcase
            if (q.tf < FMT_F32)
            begin
                r.bits = (q.tf == FMT_U32 || q.tf == FMT_S32) ? {32'd0, w[31:0]} : w;
            end
            else
            begin
                neg = (q.sf == FMT_S32 || q.sf == FMT_S64) && w[63];
                w = neg ? (64'd0 - w) : w;
                r.bits = (q.tf == FMT_F32) ? pack_fp(neg, w, 0, 8, 23)
                                           : pack_fp(neg, w, 0, 11, 52);
            end
        end
        else
        begin
            p = (q.sf == FMT_F32) ? split_fp({32'd0, q.v[31:0]}, 8, 23)
                                  : split_fp(q.v, 11, 52);
            if (q.tf < FMT_F32)
            begin
                r = fp_to_int(p, q.tf);
            end
            else if (q.tf == FMT_F64)
            begin
                if (p.cls == 2)
                begin
                    r.bits = {p.neg, 63'h7FF8000000000000} | (p.frac << 29);
                end
                else if (p.cls == 1)
                begin
                    r.bits = {p.neg, 63'h7FF0000000000000};
                end
                else
                begin
                    r.bits = pack_fp(p.neg, p.m, p.e, 11, 52);
                end
            end
            else
            begin
                if (p.cls == 2)
                begin
                    r.bits = {32'd0, p.neg, 31'h7FC00000} | (p.frac >> 29);
                end
                else if (p.cls == 1)
                begin
                    r.bits = {32'd0, p.neg, 31'h7F800000};
                end
                else
                begin
                    r.bits = pack_fp(p.neg, p.m, p.e, 8, 23);
                end
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] random_value(input logic [2:0] sf);
        logic [63:0] v;
        logic [63:0] lo;
        int pick;
        v = {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        if (sf == FMT_F32)
        begin
            lo = v & 64'hFFFFFFFF;
            case (pick)
                0: lo = {32'd0, v[31], 8'hFF, v[22:0]};
                1: lo = {32'd0, v[31], 8'h00, v[22:0]};
                2, 3, 4: lo = {32'd0, v[31], 8'd100 + {2'b0, v[29:24]}, v[22:0]};
                5: lo = {32'd0, v[31], 8'd180 + {4'b0, v[27:24]}, v[22:0]};
                default: lo = lo;
            endcase
            v = {v[63:32], lo[31:0]};
        end
        else if (sf == FMT_F64)
        begin
            case (pick)
                0: v = {v[63], 11'h7FF, v[51:0]};
                1: v = {v[63], 11'h000, v[51:0]};
                2, 3, 4: v = {v[63], 11'd990 + {5'b0, v[57:52]}, v[51:0]};
                5: v = {v[63], 11'd1050 + {6'b0, v[56:52]}, v[51:0]};
                6: v = {v[63], 11'd880 + {2'b0, v[60:52]}, v[51:0]};
                default: v = v;
            endcase
        end
        else
        begin
            case (pick)
                0: v = v >> $urandom_range(0, 63);
                1: v = 64'd0 - (v >> $urandom_range(0, 63));
                2: v = v & {$urandom, $urandom};
                default: v = v;
            endcase
        end
        return v;
    endfunction

    task automatic queue_conversion(input logic [2:0] sf, input logic [2:0] tf,
                                    input logic [63:0] v);
        conv_req_t q;
        q.sf = sf;
        q.tf = tf;
        q.v = v;
        pending_reqs.push_back(q);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.source_format <= '0;
            in_ch.target_format <= '0;
            in_ch.value_bits <= '0;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                expected_results.push_back(predict_conversion(pending_reqs.pop_front()));
            end
            if ((!in_ch.valid || in_ch.ready) )
            begin
                if (pending_reqs.size() != 0 && ($urandom_range(0, 99) >= send_idle_pct))
                begin
                    in_ch.valid <= 1'b1;
                    in_ch.source_format <= pending_reqs[0].sf;
                    in_ch.target_format <= pending_reqs[0].tf;
                    in_ch.value_bits <= pending_reqs[0].v;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        conv_res_t exp_r;
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            begin
                quiet_cycles <= 0;
            end
            else if (!stimulus_done)
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result %h oor %b", $time,
                             out_ch.result_bits, out_ch.out_of_range);
                    error_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (exp_r.bits !== out_ch.result_bits)
                    begin
                        $display("%0t: result_bits expected %h actual %h", $time,
                                 exp_r.bits, out_ch.result_bits);
                        error_count++;
                    end
                    if (exp_r.oor !== out_ch.out_of_range)
                    begin
                        $display("%0t: out_of_range expected %b actual %b", $time,
                                 exp_r.oor, out_ch.out_of_range);
                        error_count++;
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("numeric_type_converter regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        logic [2:0] sf;
        logic [2:0] tf;
        error_count = 0;
        quiet_cycles = 0;
        stimulus_done = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.source_format = '0;
        in_ch.target_format = '0;
        in_ch.value_bits = '0;
        out_ch.ready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        queue_conversion(FMT_U32, FMT_U32, 64'hDEADBEEF_12345678);
        queue_conversion(3'd6, 3'd6, '1);
        queue_conversion(3'd7, FMT_U64, 64'd5);
        queue_conversion(FMT_U32, FMT_U64, 64'hFFFFFFFF_FFFFFFFF);
        queue_conversion(FMT_S32, FMT_S64, 64'h00000000_80000000);
        queue_conversion(FMT_S64, FMT_U32, 64'h8000000000000000);
        queue_conversion(FMT_U64, FMT_F32, '1);
        queue_conversion(FMT_S64, FMT_F64, 64'h8000000000000000);
        queue_conversion(FMT_U64, FMT_F64, 64'h0020000000000001);
        queue_conversion(FMT_U32, FMT_F32, 64'h01000003);
        queue_conversion(FMT_F32, FMT_U32, 64'h7FC00001);
        queue_conversion(FMT_F64, FMT_S64, 64'hFFF0000000000000);
        queue_conversion(FMT_F64, FMT_S32, 64'h41E0000000000000);
        queue_conversion(FMT_F64, FMT_U64, 64'hBFE0000000000000);
        queue_conversion(FMT_F32, FMT_U64, 64'hBF800000);
        queue_conversion(FMT_F32, FMT_S64, 64'hDF000000);
        queue_conversion(FMT_F32, FMT_F64, 64'hFFFFFFFF_FFBFFFFF);
        queue_conversion(FMT_F64, FMT_F32, 64'h7FF7FFFFFFFFFFFF);
        queue_conversion(FMT_F64, FMT_F32, 64'h47EFFFFFF0000000);
        queue_conversion(FMT_F64, FMT_F32, 64'h36A0000000000001);
        queue_conversion(FMT_F64, FMT_F32, 64'h0000000000000001);
        queue_conversion(FMT_F32, FMT_F64, 64'h00000001);
        queue_conversion(FMT_F64, FMT_F32, 64'h7FF0000000000000);
        queue_conversion(FMT_F32, FMT_S32, 64'h80000000);
        wait_drained();

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1) ? 50 : (phase == 3) ? 31 : 0;
            recv_stall_pct = (phase == 2) ? 50 : (phase == 3) ? 31 : 0;
            for (int n = 0; n < 138; n++)
            begin
                sf = (n % 20 == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 5));
                tf = (n % 20 == 1) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 5));
                queue_conversion(sf, tf, random_value(sf));
            end
            wait_drained();
        end

        stimulus_done = 1'b1;
        repeat (10) @(posedge clk);
        if (error_count == 0)
        begin
            $display("numeric_type_converter regression: pass");
        end
        else
        begin
            $display("numeric_type_converter regression: fail");
        end
        $finish;
    end
endmodule
